// File: design/repeating_xor_key_recovery_core_defines.svh
// Assertion macros used by the key recovery top-level design file.
// Depends on nothing; expects clk_i and rst_ni in the including module.
`ifndef REPEATING_XOR_KEY_RECOVERY_CORE_DEFINES_SVH
`define REPEATING_XOR_KEY_RECOVERY_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define RXK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define RXK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RXK_ASSERT(lbl, prop, msg)
`define RXK_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: design/rxk_pkg.sv
// Shared types and constants of the repeating-key XOR key recovery core.
// Depends on nothing; used by rxk_cell and the top level.
package rxk_pkg;

  localparam int MaxKeyLengthDef = 32;
  localparam int CountWidthDef   = 16;
  localparam int NUM_CELLS       = 4;
  localparam int CELL_W          = 2;
  localparam int GRP_W           = 8 - CELL_W;
  localparam int SYM_W           = 8;
  localparam int WEIGHT_W        = 16;
  localparam int LEN_W           = 7;
  localparam int NUM_SYMS        = 256;

  // Request codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_BYTE   = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // Register indexes
  localparam logic REG_KEY_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CNT,
    ST_SCORE,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic [1:0]          func;
    logic [SYM_W-1:0]    symbol;
    logic [WEIGHT_W-1:0] weight;
  } req_t;

  typedef struct packed {
    logic [4:0]       column;
    logic [SYM_W-1:0] key_byte;
    logic             found;
    logic             last;
  } res_t;

  // Histogram stream travelling along the cell row
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             endg;
    logic             fin;
    logic [GRP_W-1:0] grp;
    logic [SYM_W-1:0] sym;
  } tag_t;

  // Best-so-far token travelling along the cell row
  typedef struct packed {
    logic             vld;
    logic             fin;
    logic [SYM_W-1:0] key;
  } tok_t;

endpackage

// File: design/rxk_cell.sv
// One scoring cell: evaluates one key candidate against the histogram stream.
// Depends on rxk_pkg; instantiated in a row by the top level.
module rxk_cell #(
  parameter int COUNT_W = rxk_pkg::CountWidthDef,
  parameter int IDX     = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [rxk_pkg::SYM_W-1:0]     wr_addr_i,
  input  logic [rxk_pkg::WEIGHT_W-1:0]  wr_data_i,
  input  logic [rxk_pkg::NUM_SYMS-1:0]  wvld_i,
  input  rxk_pkg::tag_t                 tag_i,
  input  logic [COUNT_W-1:0]            cnt_i,
  output rxk_pkg::tag_t                 tag_o,
  output logic [COUNT_W-1:0]            cnt_o,
  input  rxk_pkg::tok_t                 tok_i,
  input  logic [COUNT_W+23:0]           tok_score_i,
  output rxk_pkg::tok_t                 tok_o,
  output logic [COUNT_W+23:0]           tok_score_o
);

  localparam int PROD_W  = rxk_pkg::WEIGHT_W + COUNT_W;
  localparam int SCORE_W = PROD_W + rxk_pkg::SYM_W;

  logic [rxk_pkg::WEIGHT_W-1:0] wmem [rxk_pkg::NUM_SYMS];

  logic [rxk_pkg::SYM_W-1:0]    key_a, p_a;
  logic                         bad_a;
  rxk_pkg::tag_t                a_tag_q, b_tag_q;
  logic [COUNT_W-1:0]           a_cnt_q;
  logic [rxk_pkg::WEIGHT_W-1:0] wd_q;
  logic                         wv_q, bad_a_q, bad_b_q;
  logic [PROD_W-1:0]            prod_q;
  logic [SCORE_W-1:0]           acc_q, acc_d;
  logic                         bad_q, bad_d;
  logic                         cand_vld_q, cand_fin_q, cand_ok_q;
  logic [rxk_pkg::SYM_W-1:0]    cand_key_q;
  logic [SCORE_W-1:0]           cand_score_q;
  rxk_pkg::tok_t                tok_q;
  logic [SCORE_W-1:0]           tok_score_q;

  // Look up the plaintext character for this key
  assign key_a = {tag_i.grp, rxk_pkg::CELL_W'(IDX)};
  assign p_a   = tag_i.sym ^ key_a;
  assign bad_a = (cnt_i != '0) && (p_a[7] || (p_a[6:5] == 2'b00));

  // Hold the weight copy; broadcast writes from the load request
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      wmem[wr_addr_i] <= wr_data_i;
    end
    wd_q    <= wmem[p_a];
    a_cnt_q <= cnt_i;
    prod_q  <= (wv_q ? wd_q : '0) * a_cnt_q;
  end

  // Accumulate the score of this key over the column
  always_comb begin
    acc_d = (b_tag_q.first ? '0 : acc_q) + SCORE_W'(prod_q);
    bad_d = (b_tag_q.first ? 1'b0 : bad_q) | bad_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q      <= '0;
      b_tag_q      <= '0;
      wv_q         <= 1'b0;
      bad_a_q      <= 1'b0;
      bad_b_q      <= 1'b0;
      acc_q        <= '0;
      bad_q        <= 1'b0;
      cand_vld_q   <= 1'b0;
      cand_fin_q   <= 1'b0;
      cand_ok_q    <= 1'b0;
      cand_key_q   <= '0;
      cand_score_q <= '0;
      tok_q        <= '0;
      tok_score_q  <= '0;
    end else begin
      a_tag_q    <= tag_i;
      wv_q       <= wvld_i[p_a];
      bad_a_q    <= bad_a;
      b_tag_q    <= a_tag_q;
      bad_b_q    <= bad_a_q;
      cand_vld_q <= 1'b0;
      if (b_tag_q.vld) begin
        acc_q <= acc_d;
        bad_q <= bad_d;
        if (b_tag_q.endg) begin
          cand_vld_q   <= 1'b1;
          cand_fin_q   <= b_tag_q.fin;
          cand_ok_q    <= !bad_d;
          cand_key_q   <= {b_tag_q.grp, rxk_pkg::CELL_W'(IDX)};
          cand_score_q <= acc_d;
        end
      end
      // Pass on the better of the incoming best and this key
      tok_q.vld <= cand_vld_q;
      tok_q.fin <= cand_fin_q;
      if (cand_ok_q && (cand_score_q > tok_score_i)) begin
        tok_q.key   <= cand_key_q;
        tok_score_q <= cand_score_q;
      end else begin
        tok_q.key   <= tok_i.key;
        tok_score_q <= tok_score_i;
      end
    end
  end

  assign tag_o       = a_tag_q;
  assign cnt_o       = a_cnt_q;
  assign tok_o       = tok_q;
  assign tok_score_o = tok_score_q;

endmodule

// File: design/repeating_xor_key_recovery_core.sv
// Repeating-key XOR key recovery: histogram store, controller and scoring row.
// Depends on rxk_pkg, rxk_cell and repeating_xor_key_recovery_core_defines.svh.
// Weight load: written when accepted. Ciphertext byte: histogram read, then write back.
// Finish: per column every group and symbol is streamed through the cell row,
// one result per column; after the last column all MAX_KEY_LEN*256 histogram
// entries are cleared through the single histogram port. Results cannot be stalled.
// After reset the same clear runs (busy high); configuration is taken throughout.
`include "repeating_xor_key_recovery_core_defines.svh"

module repeating_xor_key_recovery_core #(
  parameter int MAX_KEY_LEN = rxk_pkg::MaxKeyLengthDef,
  parameter int COUNT_WIDTH = rxk_pkg::CountWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rxk_pkg::req_t req_i,
  output logic          res_valid_o,
  output rxk_pkg::res_t res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int COL_W   = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int AW      = COL_W + rxk_pkg::SYM_W;
  localparam int HDEPTH  = MAX_KEY_LEN * rxk_pkg::NUM_SYMS;
  localparam int SCORE_W = COUNT_WIDTH + 24;
  localparam int NC      = rxk_pkg::NUM_CELLS;

  rxk_pkg::state_e state_q, state_d;

  logic [5:0]                  key_length_q;
  logic [rxk_pkg::LEN_W-1:0]   len, colsel, colnext;
  logic [rxk_pkg::LEN_W-1:0]   col_q, col_d, ptr_q, ptr_d;
  logic [rxk_pkg::GRP_W-1:0]   grp_q, grp_d;
  logic [rxk_pkg::SYM_W-1:0]   sym_q, sym_d;
  logic [AW-1:0]               clr_q, clr_d, cnt_addr_q, cnt_addr_d;
  logic                        hist_we;
  logic [AW-1:0]               hist_wa, hist_ra;
  logic [COUNT_WIDTH-1:0]      hist_wd, hist_rd_q;
  logic [COUNT_WIDTH-1:0]      hist_mem [HDEPTH];
  rxk_pkg::tag_t               s_tag_q, s_tag_d;
  logic [SCORE_W-1:0]          best_score_q, best_score_d;
  logic [rxk_pkg::SYM_W-1:0]   best_key_q, best_key_d;
  logic                        res_vld_d;
  rxk_pkg::res_t               res_q, res_d;
  logic                        res_vld_q;
  logic [rxk_pkg::NUM_SYMS-1:0] wv_q;
  logic                        accept, wload, cfg_wr;

  rxk_pkg::tag_t               tag_w   [NC+1];
  logic [COUNT_WIDTH-1:0]      cnt_w   [NC+1];
  rxk_pkg::tok_t               tok_w   [NC+1];
  logic [SCORE_W-1:0]          score_w [NC+1];
  rxk_pkg::tok_t               tok_end;

  assign busy   = (state_q != rxk_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign wload  = accept && (req_i.func == rxk_pkg::FUNC_LOAD);

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == rxk_pkg::REG_KEY_LENGTH) ? {26'd0, key_length_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= 6'd31;
    end else if (cfg_wr && (paddr[2] == rxk_pkg::REG_KEY_LENGTH)) begin
      key_length_q <= pwdata[5:0];
    end
  end

  // Clamp the key length to the supported range
  always_comb begin
    if (key_length_q == '0) begin
      len = rxk_pkg::LEN_W'(1);
    end else if ({1'b0, key_length_q} > rxk_pkg::LEN_W'(MAX_KEY_LEN)) begin
      len = rxk_pkg::LEN_W'(MAX_KEY_LEN);
    end else begin
      len = {1'b0, key_length_q};
    end
  end

  // Weight valid bits; unwritten weights read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= '0;
    end else if (wload) begin
      wv_q[req_i.symbol] <= 1'b1;
    end
  end

  // Histogram memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_q <= hist_mem[hist_ra];
  end

  // Scoring row
  assign tag_w[0]   = s_tag_q;
  assign cnt_w[0]   = hist_rd_q;
  assign tok_w[0]   = '{vld: 1'b0, fin: 1'b0, key: best_key_q};
  assign score_w[0] = best_score_q;
  assign tok_end    = tok_w[NC];

  for (genvar g = 0; g < NC; g++) begin : g_cell
    rxk_cell #(
      .COUNT_W(COUNT_WIDTH),
      .IDX    (g)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .wr_en_i    (wload),
      .wr_addr_i  (req_i.symbol),
      .wr_data_i  (req_i.weight),
      .wvld_i     (wv_q),
      .tag_i      (tag_w[g]),
      .cnt_i      (cnt_w[g]),
      .tag_o      (tag_w[g+1]),
      .cnt_o      (cnt_w[g+1]),
      .tok_i      (tok_w[g]),
      .tok_score_i(score_w[g]),
      .tok_o      (tok_w[g+1]),
      .tok_score_o(score_w[g+1])
    );
  end

  // Controller: next state and datapath controls
  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    ptr_d        = ptr_q;
    grp_d        = grp_q;
    sym_d        = sym_q;
    clr_d        = clr_q;
    cnt_addr_d   = cnt_addr_q;
    hist_we      = 1'b0;
    hist_wa      = clr_q;
    hist_wd      = '0;
    hist_ra      = {col_q[COL_W-1:0], sym_q};
    s_tag_d      = '0;
    best_score_d = best_score_q;
    best_key_d   = best_key_q;
    res_vld_d    = 1'b0;
    res_d        = res_q;
    colsel       = (ptr_q >= len) ? '0 : ptr_q;
    colnext      = colsel + rxk_pkg::LEN_W'(1);

    case (state_q)
      rxk_pkg::ST_CLR: begin
        hist_we = 1'b1;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(HDEPTH - 1)) begin
          clr_d   = '0;
          state_d = rxk_pkg::ST_IDLE;
        end
      end
      rxk_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.func)
            rxk_pkg::FUNC_BYTE: begin
              hist_ra    = {colsel[COL_W-1:0], req_i.symbol};
              cnt_addr_d = {colsel[COL_W-1:0], req_i.symbol};
              ptr_d      = (colnext >= len) ? '0 : colnext;
              state_d    = rxk_pkg::ST_CNT;
            end
            rxk_pkg::FUNC_FINISH: begin
              col_d   = '0;
              grp_d   = '0;
              sym_d   = '0;
              state_d = rxk_pkg::ST_SCORE;
            end
            default: begin
            end
          endcase
        end
      end
      rxk_pkg::ST_CNT: begin
        // Saturating increment of the counted entry
        hist_we = 1'b1;
        hist_wa = cnt_addr_q;
        hist_wd = (hist_rd_q == '1) ? hist_rd_q : hist_rd_q + COUNT_WIDTH'(1);
        state_d = rxk_pkg::ST_IDLE;
      end
      rxk_pkg::ST_SCORE: begin
        s_tag_d.vld   = 1'b1;
        s_tag_d.first = (sym_q == '0);
        s_tag_d.endg  = (sym_q == '1);
        s_tag_d.fin   = (sym_q == '1) && (grp_q == '1);
        s_tag_d.grp   = grp_q;
        s_tag_d.sym   = sym_q;
        sym_d         = sym_q + rxk_pkg::SYM_W'(1);
        if (sym_q == '1) begin
          grp_d = grp_q + rxk_pkg::GRP_W'(1);
          if (grp_q == '1) begin
            state_d = rxk_pkg::ST_WAIT;
          end
        end
      end
      rxk_pkg::ST_WAIT: begin
      end
      default: begin
        state_d = rxk_pkg::ST_CLR;
      end
    endcase

    // Take the best key of each finished group
    if (tok_end.vld) begin
      best_score_d = score_w[NC];
      best_key_d   = tok_end.key;
      if (tok_end.fin) begin
        res_vld_d      = 1'b1;
        res_d.column   = col_q[4:0];
        res_d.found    = (score_w[NC] != '0);
        res_d.key_byte = (score_w[NC] != '0) ? tok_end.key : '0;
        res_d.last     = ((col_q + rxk_pkg::LEN_W'(1)) >= len);
        best_score_d   = '0;
        best_key_d     = '0;
        grp_d          = '0;
        sym_d          = '0;
        if ((col_q + rxk_pkg::LEN_W'(1)) >= len) begin
          ptr_d   = '0;
          clr_d   = '0;
          state_d = rxk_pkg::ST_CLR;
        end else begin
          col_d   = col_q + rxk_pkg::LEN_W'(1);
          state_d = rxk_pkg::ST_SCORE;
        end
      end
    end
  end

  // Control and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rxk_pkg::ST_CLR;
      col_q        <= '0;
      ptr_q        <= '0;
      grp_q        <= '0;
      sym_q        <= '0;
      clr_q        <= '0;
      cnt_addr_q   <= '0;
      s_tag_q      <= '0;
      best_score_q <= '0;
      best_key_q   <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      ptr_q        <= ptr_d;
      grp_q        <= grp_d;
      sym_q        <= sym_d;
      clr_q        <= clr_d;
      cnt_addr_q   <= cnt_addr_d;
      s_tag_q      <= s_tag_d;
      best_score_q <= best_score_d;
      best_key_q   <= best_key_d;
      res_vld_q    <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  `RXK_ASSERT(a_res_in_finish, res_valid_o |-> busy, "result strobe outside finish")
  `RXK_ASSERT(a_nf_key_zero, res_valid_o && !res_o.found |-> res_o.key_byte == '0, "key without find")
  `RXK_ASSERT(a_byte_wb, start && !busy && req_i.func == rxk_pkg::FUNC_BYTE |=> state_q == rxk_pkg::ST_CNT, "no histogram write back")
  `RXK_ASSERT(a_fin_in_wait, tok_end.vld && tok_end.fin |-> state_q == rxk_pkg::ST_WAIT, "column end outside wait")
  `RXK_ASSERT_RST(a_rst_clear, !rst_ni |=> state_q == rxk_pkg::ST_CLR && !res_valid_o, "reset state wrong")

endmodule
